// ===== design/vtg_pkg.sv =====
// ---------------------------------------------------------------------------
// vtg_pkg
// Shared types, character codes and helper functions for the VTG field parser.
// ---------------------------------------------------------------------------
package vtg_pkg;

  localparam int FRAC_DIGITS_DEF = 3;
  localparam int VALUE_BITS_DEF  = 24;

  localparam int CHAR_W  = 8;
  localparam int STAMP_W = 32;
  localparam int MILLI_W = 24;
  localparam int FLAG_W  = 8;
  localparam int HEX_W   = 8;
  localparam int POS_W   = 4;
  // 10^6 fits in 20 bits (largest supported fraction digit count)
  localparam int POW_W   = 20;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 176;

  localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_STAR    = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_VT      = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF      = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_POINT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LC_A    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_F    = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UC_A    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC_F    = 8'h46;

  // field positions: 0..7 the eight body fields, then mode and checksum
  localparam logic [POS_W-1:0] POS_TRUE_COURSE = 4'd0;
  localparam logic [POS_W-1:0] POS_MODE        = 4'd8;
  localparam logic [POS_W-1:0] POS_CSUM        = 4'd9;

  localparam logic [2:0] FLAG_IDX_MODE = 3'd4;

  typedef enum logic [2:0] {
    KIND_COMMA,
    KIND_STAR,
    KIND_NEWLINE,
    KIND_SPACE,
    KIND_TEXT
  } char_kind_t;

  typedef struct packed {
    logic [STAMP_W-1:0] now_us;
    logic [CHAR_W-1:0]  rx_char;
  } item_t;

  typedef struct packed {
    logic       fire;
    char_kind_t kind;
  } step_t;

  typedef struct packed {
    logic       take;
    logic       clear;
    logic       store_num;
    logic       store_flag;
    logic       store_mode;
    logic       latch_time;
    logic       emit;
    logic [1:0] slot;
  } ctl_t;

  function automatic char_kind_t char_kind(input logic [CHAR_W-1:0] c);
    char_kind_t k;
    unique case (c)
      CH_COMMA:   k = KIND_COMMA;
      CH_STAR:    k = KIND_STAR;
      CH_NEWLINE: k = KIND_NEWLINE;
      CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_FF: k = KIND_SPACE;
      default:    k = KIND_TEXT;
    endcase
    return k;
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_digit(input logic [CHAR_W-1:0] c);
    logic [4:0] r;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= CH_LC_A && c <= CH_LC_F) || (c >= CH_UC_A && c <= CH_UC_F)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

  function automatic logic [POW_W-1:0] pow10(input logic [2:0] k);
    logic [POW_W-1:0] m;
    unique case (k)
      3'd0:    m = 20'd1;
      3'd1:    m = 20'd10;
      3'd2:    m = 20'd100;
      3'd3:    m = 20'd1000;
      3'd4:    m = 20'd10000;
      3'd5:    m = 20'd100000;
      3'd6:    m = 20'd1000000;
      default: m = 20'd1;
    endcase
    return m;
  endfunction

endpackage

// ===== design/nmea_vtg_sentence_field_parser_core.sv =====
// ---------------------------------------------------------------------------
// nmea_vtg_sentence_field_parser_core
// VTG sentence body parser: one character per transaction, one record per line.
// ---------------------------------------------------------------------------
// Accepts one sentence character per clock unless a newline waits behind a
// stalled result. A character is held in the input register, then the field
// update and record update happen in the same cycle into the result register,
// so a newline's record passes the input register and then the result
// register on its way to out_*. The field update (decimal accumulate plus one
// saturating scale multiply) is the per-cycle loop that sets this rate. Only a
// newline yields a transaction on the output; a stalled output holds the input
// side only once a second newline is waiting behind it.
module nmea_vtg_sentence_field_parser_core #(
  parameter int FRAC_DIGITS = vtg_pkg::FRAC_DIGITS_DEF,
  parameter int VALUE_BITS  = vtg_pkg::VALUE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [7:0] rx_char, [39:8] now_us
  input  logic [39:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [23:0] course_true_milli, [31:24] course_true_flag, [55:32] course_mag_milli,
  // [63:56] course_mag_flag, [87:64] speed_knots_milli, [95:88] speed_knots_flag,
  // [119:96] speed_kph_milli, [127:120] speed_kph_flag, [135:128] mode_flag,
  // [143:136] checksum_value, [175:144] stamp_us
  output logic [175:0] out_tdata
);

  logic                         in_v_r, in_v_nxt;
  vtg_pkg::item_t               in_item_r;
  logic                         in_acc;
  logic                         fire;
  vtg_pkg::step_t               step;
  vtg_pkg::ctl_t                ctl;
  logic [VALUE_BITS-1:0]        scaled;
  logic [vtg_pkg::FLAG_W-1:0]   first_char;
  logic [vtg_pkg::HEX_W-1:0]    hex_value;

  // the held character moves on unless it would emit into a full, stalled result
  assign fire      = in_v_r && ((step.kind != vtg_pkg::KIND_NEWLINE) ||
                                !out_tvalid || out_tready);
  assign in_tready = !in_v_r || fire;
  assign in_acc    = in_tvalid && in_tready;

  assign step.fire = fire;
  assign step.kind = vtg_pkg::char_kind(in_item_r.rx_char);

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_acc) begin
      in_v_nxt = 1'b1;
    end else if (fire) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) in_item_r <= vtg_pkg::item_t'(in_tdata);
  end

  vtg_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .ctl   (ctl)
  );

  vtg_field_acc #(
    .FRAC_DIGITS (FRAC_DIGITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_field_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .ch         (in_item_r.rx_char),
    .scaled     (scaled),
    .first_char (first_char),
    .hex_value  (hex_value)
  );

  vtg_record #(
    .VALUE_BITS (VALUE_BITS)
  ) u_record (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .now_us     (in_item_r.now_us),
    .scaled     (scaled),
    .first_char (first_char),
    .hex_value  (hex_value),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_newline_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && step.kind == vtg_pkg::KIND_NEWLINE) |=> out_tvalid)
    else $error("newline transaction produced no result");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_v_r && out_tvalid && !out_tready))
    else $error("input stalled without a blocked result");

  a_held_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !fire) |=> (in_v_r && $stable(in_item_r)))
    else $error("waiting character lost or changed");

endmodule

// ===== design/vtg_seq.sv =====
// ---------------------------------------------------------------------------
// vtg_seq
// Field position tracker; decodes each character into record/field controls.
// ---------------------------------------------------------------------------
module vtg_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  vtg_pkg::step_t step,
  output vtg_pkg::ctl_t  ctl
);

  logic [vtg_pkg::POS_W-1:0] pos_r;
  logic [vtg_pkg::POS_W-1:0] pos_nxt;
  logic                      comma_act;

  assign comma_act = step.fire && (step.kind == vtg_pkg::KIND_COMMA) &&
                     (pos_r < vtg_pkg::POS_MODE);

  always_comb begin
    pos_nxt = pos_r;
    if (step.fire) begin
      unique case (step.kind)
        vtg_pkg::KIND_COMMA:   if (comma_act) pos_nxt = pos_r + 4'd1;
        vtg_pkg::KIND_STAR:    pos_nxt = vtg_pkg::POS_CSUM;
        vtg_pkg::KIND_NEWLINE: pos_nxt = vtg_pkg::POS_TRUE_COURSE;
        default:               pos_nxt = pos_r;
      endcase
    end
  end

  always_comb begin
    ctl            = '0;
    ctl.slot       = pos_r[2:1];
    ctl.take       = step.fire && (step.kind == vtg_pkg::KIND_TEXT);
    ctl.store_num  = comma_act && !pos_r[0];
    ctl.store_flag = comma_act && pos_r[0];
    ctl.latch_time = comma_act && (pos_r == vtg_pkg::POS_TRUE_COURSE);
    ctl.store_mode = step.fire && (step.kind == vtg_pkg::KIND_STAR);
    ctl.emit       = step.fire && (step.kind == vtg_pkg::KIND_NEWLINE);
    ctl.clear      = comma_act || ctl.store_mode || ctl.emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= vtg_pkg::POS_TRUE_COURSE;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// ===== design/vtg_field_acc.sv =====
// ---------------------------------------------------------------------------
// vtg_field_acc
// Per-field accumulators: decimal fixed point value, first character, hex.
// ---------------------------------------------------------------------------
module vtg_field_acc #(
  parameter int FRAC_DIGITS = vtg_pkg::FRAC_DIGITS_DEF,
  parameter int VALUE_BITS  = vtg_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  vtg_pkg::ctl_t                 ctl,
  input  logic [vtg_pkg::CHAR_W-1:0]    ch,
  output logic [VALUE_BITS-1:0]         scaled,
  output logic [vtg_pkg::FLAG_W-1:0]    first_char,
  output logic [vtg_pkg::HEX_W-1:0]     hex_value
);

  localparam int FC_W   = (FRAC_DIGITS < 1) ? 1 : $clog2(FRAC_DIGITS + 1);
  localparam int SUM_W  = VALUE_BITS + 4;
  localparam int PROD_W = VALUE_BITS + vtg_pkg::POW_W;
  localparam logic [FC_W-1:0]       FRAC_MAX = FC_W'(FRAC_DIGITS);
  localparam logic [VALUE_BITS-1:0] MAXV     = {VALUE_BITS{1'b1}};

  logic [VALUE_BITS-1:0]      acc_r, acc_nxt;
  logic [FC_W-1:0]            frac_r, frac_nxt;
  logic                       point_r, point_nxt;
  logic                       stop_r, stop_nxt;
  logic                       seen_r, seen_nxt;
  logic [vtg_pkg::FLAG_W-1:0] first_r, first_nxt;
  logic [vtg_pkg::HEX_W-1:0]  hex_r, hex_nxt;
  logic                       hex_stop_r, hex_stop_nxt;

  logic                       is_digit;
  logic [SUM_W-1:0]           sum;
  logic [VALUE_BITS-1:0]      acc_dig;
  logic [4:0]                 hd;
  logic [FC_W-1:0]            shift_k;
  logic [PROD_W-1:0]          prod;

  assign is_digit = (ch >= vtg_pkg::CH_ZERO) && (ch <= vtg_pkg::CH_NINE);
  assign sum      = (SUM_W'(acc_r) << 3) + (SUM_W'(acc_r) << 1) + SUM_W'(ch[3:0]);
  assign acc_dig  = (|sum[SUM_W-1:VALUE_BITS]) ? MAXV : sum[VALUE_BITS-1:0];
  assign hd       = vtg_pkg::hex_digit(ch);

  // pad missing fraction digits: value * 10^(FRAC_DIGITS - digits read), saturating
  assign shift_k = FRAC_MAX - frac_r;
  assign prod    = PROD_W'(acc_r) * PROD_W'(vtg_pkg::pow10(3'(shift_k)));
  assign scaled  = (|prod[PROD_W-1:VALUE_BITS]) ? MAXV : prod[VALUE_BITS-1:0];

  assign first_char = first_r;
  assign hex_value  = hex_r;

  always_comb begin
    acc_nxt      = acc_r;
    frac_nxt     = frac_r;
    point_nxt    = point_r;
    stop_nxt     = stop_r;
    seen_nxt     = seen_r;
    first_nxt    = first_r;
    hex_nxt      = hex_r;
    hex_stop_nxt = hex_stop_r;
    if (ctl.clear) begin
      acc_nxt      = '0;
      frac_nxt     = '0;
      point_nxt    = 1'b0;
      stop_nxt     = 1'b0;
      seen_nxt     = 1'b0;
      first_nxt    = '0;
      hex_nxt      = '0;
      hex_stop_nxt = 1'b0;
    end else if (ctl.take) begin
      if (!seen_r) begin
        first_nxt = ch;
        seen_nxt  = 1'b1;
      end
      if (!stop_r) begin
        if (is_digit) begin
          if (!point_r) begin
            acc_nxt = acc_dig;
          end else if (frac_r < FRAC_MAX) begin
            acc_nxt  = acc_dig;
            frac_nxt = frac_r + FC_W'(1);
          end
        end else if (ch == vtg_pkg::CH_POINT && !point_r) begin
          point_nxt = 1'b1;
        end else begin
          stop_nxt = 1'b1;
        end
      end
      if (!hex_stop_r) begin
        if (hd[4]) begin
          hex_nxt = {hex_r[3:0], hd[3:0]};
        end else begin
          hex_stop_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      frac_r     <= '0;
      point_r    <= 1'b0;
      stop_r     <= 1'b0;
      seen_r     <= 1'b0;
      first_r    <= '0;
      hex_r      <= '0;
      hex_stop_r <= 1'b0;
    end else begin
      acc_r      <= acc_nxt;
      frac_r     <= frac_nxt;
      point_r    <= point_nxt;
      stop_r     <= stop_nxt;
      seen_r     <= seen_nxt;
      first_r    <= first_nxt;
      hex_r      <= hex_nxt;
      hex_stop_r <= hex_stop_nxt;
    end
  end

  a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
    frac_r <= FRAC_MAX)
    else $error("fraction digit count beyond limit");

  a_frac_needs_point: assert property (@(posedge clk) disable iff (!rst_n)
    (frac_r != '0) |-> point_r)
    else $error("fraction digits counted without a decimal point");

  a_empty_field: assert property (@(posedge clk) disable iff (!rst_n)
    !seen_r |-> (first_r == '0) && (acc_r == '0) && (hex_r == '0) && !stop_r)
    else $error("field holds data before any character was taken");

endmodule

// ===== design/vtg_record.sv =====
// ---------------------------------------------------------------------------
// vtg_record
// Sentence record storage, time latch and the result register.
// ---------------------------------------------------------------------------
module vtg_record #(
  parameter int VALUE_BITS = vtg_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  vtg_pkg::ctl_t                ctl,
  input  logic [vtg_pkg::STAMP_W-1:0]  now_us,
  input  logic [VALUE_BITS-1:0]        scaled,
  input  logic [vtg_pkg::FLAG_W-1:0]   first_char,
  input  logic [vtg_pkg::HEX_W-1:0]    hex_value,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [vtg_pkg::OUT_W-1:0]    out_tdata
);

  logic [VALUE_BITS-1:0]       num_rec_r [4];
  logic [vtg_pkg::FLAG_W-1:0]  flag_rec_r [5];
  logic [vtg_pkg::STAMP_W-1:0] time_r;
  logic                        out_valid_r, out_valid_nxt;
  logic [vtg_pkg::OUT_W-1:0]   out_data_r, out_data_nxt;

  assign out_data_nxt = {
    time_r,
    hex_value,
    flag_rec_r[4],
    flag_rec_r[3], vtg_pkg::MILLI_W'(num_rec_r[3]),
    flag_rec_r[2], vtg_pkg::MILLI_W'(num_rec_r[2]),
    flag_rec_r[1], vtg_pkg::MILLI_W'(num_rec_r[1]),
    flag_rec_r[0], vtg_pkg::MILLI_W'(num_rec_r[0])
  };

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) num_rec_r[i] <= '0;
      for (int i = 0; i < 5; i++) flag_rec_r[i] <= '0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.store_num) num_rec_r[ctl.slot] <= scaled;
      if (ctl.store_flag) flag_rec_r[{1'b0, ctl.slot}] <= first_char;
      if (ctl.store_mode) flag_rec_r[vtg_pkg::FLAG_IDX_MODE] <= first_char;
      if (ctl.latch_time) time_r <= now_us;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== bench/vtg_record_sb_pkg.sv =====
// ---------------------------------------------------------------------------
// vtg_record_sb_pkg
// Scoreboard for the VTG field parser. It tracks the parser state for each
// accepted character and queues the record that every newline should produce.
// ---------------------------------------------------------------------------
package vtg_record_sb_pkg;
  import vtg_pkg::*;

  // same layout as out_tdata, lowest field last
  typedef struct packed {
    logic [STAMP_W-1:0] stamp_us;
    logic [HEX_W-1:0]   checksum_value;
    logic [FLAG_W-1:0]  mode_flag;
    logic [FLAG_W-1:0]  speed_kph_flag;
    logic [MILLI_W-1:0] speed_kph_milli;
    logic [FLAG_W-1:0]  speed_knots_flag;
    logic [MILLI_W-1:0] speed_knots_milli;
    logic [FLAG_W-1:0]  course_mag_flag;
    logic [MILLI_W-1:0] course_mag_milli;
    logic [FLAG_W-1:0]  course_true_flag;
    logic [MILLI_W-1:0] course_true_milli;
  } vtg_record_t;

  localparam logic [63:0] VALUE_MAX = (64'd1 << VALUE_BITS_DEF) - 64'd1;

  class vtg_record_sb;
    logic [POS_W-1:0]   field_pos;
    logic [63:0]        num_acc;
    int unsigned        frac_cnt;
    bit                 point_seen;
    bit                 num_stopped;
    logic [CHAR_W-1:0]  first_ch;
    bit                 ch_seen;
    logic [HEX_W-1:0]   hex_acc;
    bit                 hex_stopped;
    logic [MILLI_W-1:0] value_rec[4];
    logic [FLAG_W-1:0]  flag_rec[5];
    logic [STAMP_W-1:0] stamp_latch;
    vtg_record_t        pending[$];
    int                 errors;

    function new();
      field_pos = POS_TRUE_COURSE;
      clear_field();
      foreach (value_rec[i]) value_rec[i] = '0;
      foreach (flag_rec[i]) flag_rec[i] = '0;
      stamp_latch = '0;
      errors = 0;
    endfunction

    function void clear_field();
      num_acc = '0;
      frac_cnt = 0;
      point_seen = 0;
      num_stopped = 0;
      first_ch = '0;
      ch_seen = 0;
      hex_acc = '0;
      hex_stopped = 0;
    endfunction

    function bit is_blank(logic [CHAR_W-1:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_VT || c == CH_FF;
    endfunction

    function logic [63:0] push_digit(logic [63:0] acc, logic [63:0] d);
      return (acc > (VALUE_MAX - d) / 10) ? VALUE_MAX : acc * 10 + d;
    endfunction

    // pad missing fraction digits, saturating
    function logic [63:0] scaled_value();
      logic [63:0] v;
      v = num_acc;
      for (int k = frac_cnt; k < FRAC_DIGITS_DEF; k++) begin
        v = (v > VALUE_MAX / 10) ? VALUE_MAX : v * 10;
      end
      return v;
    endfunction

    function void take_char(logic [CHAR_W-1:0] c);
      logic [3:0] nib;
      bit         is_hex;
      if (!ch_seen) begin
        first_ch = c;
        ch_seen = 1;
      end
      if (!num_stopped) begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          if (!point_seen) begin
            num_acc = push_digit(num_acc, 64'(c - CH_ZERO));
          end else if (frac_cnt < FRAC_DIGITS_DEF) begin
            num_acc = push_digit(num_acc, 64'(c - CH_ZERO));
            frac_cnt++;
          end
        end else if (c == CH_POINT && !point_seen) begin
          point_seen = 1;
        end else begin
          num_stopped = 1;
        end
      end
      if (!hex_stopped) begin
        is_hex = 1;
        nib = '0;
        if (c >= CH_ZERO && c <= CH_NINE) nib = 4'(c - CH_ZERO);
        else if (c >= CH_LC_A && c <= CH_LC_F) nib = 4'(c - CH_LC_A + 10);
        else if (c >= CH_UC_A && c <= CH_UC_F) nib = 4'(c - CH_UC_A + 10);
        else is_hex = 0;
        if (is_hex) hex_acc = {hex_acc[3:0], nib};
        else hex_stopped = 1;
      end
    endfunction

    // called for every accepted input transaction
    function void note_char(logic [CHAR_W-1:0] c, logic [STAMP_W-1:0] now);
      vtg_record_t rec;
      if (c == CH_COMMA) begin
        // commas in mode/checksum fields are ignored
        if (field_pos < POS_MODE) begin
          if (!field_pos[0]) begin
            if (field_pos == POS_TRUE_COURSE) stamp_latch = now;
            value_rec[field_pos[2:1]] = MILLI_W'(scaled_value());
          end else begin
            flag_rec[field_pos[2:1]] = first_ch;
          end
          field_pos = field_pos + 1'b1;
          clear_field();
        end
      end else if (c == CH_STAR) begin
        flag_rec[FLAG_IDX_MODE] = first_ch;
        field_pos = POS_CSUM;
        clear_field();
      end else if (c == CH_NEWLINE) begin
        rec.course_true_milli = value_rec[0];
        rec.course_true_flag  = flag_rec[0];
        rec.course_mag_milli  = value_rec[1];
        rec.course_mag_flag   = flag_rec[1];
        rec.speed_knots_milli = value_rec[2];
        rec.speed_knots_flag  = flag_rec[2];
        rec.speed_kph_milli   = value_rec[3];
        rec.speed_kph_flag    = flag_rec[3];
        rec.mode_flag         = flag_rec[FLAG_IDX_MODE];
        rec.checksum_value    = hex_acc;
        rec.stamp_us          = stamp_latch;
        pending.push_back(rec);
        field_pos = POS_TRUE_COURSE;
        clear_field();
      end else if (!is_blank(c)) begin
        take_char(c);
      end
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // called for every accepted output transaction
    function void check_record(logic [OUT_W-1:0] raw);
      vtg_record_t got;
      vtg_record_t want;
      got = raw;
      if (pending.size() == 0) begin
        $error("record with no newline pending: 0x%0h", raw);
        errors++;
        return;
      end
      want = pending.pop_front();
      cmp_field("course_true_milli", want.course_true_milli, got.course_true_milli);
      cmp_field("course_true_flag", want.course_true_flag, got.course_true_flag);
      cmp_field("course_mag_milli", want.course_mag_milli, got.course_mag_milli);
      cmp_field("course_mag_flag", want.course_mag_flag, got.course_mag_flag);
      cmp_field("speed_knots_milli", want.speed_knots_milli, got.speed_knots_milli);
      cmp_field("speed_knots_flag", want.speed_knots_flag, got.speed_knots_flag);
      cmp_field("speed_kph_milli", want.speed_kph_milli, got.speed_kph_milli);
      cmp_field("speed_kph_flag", want.speed_kph_flag, got.speed_kph_flag);
      cmp_field("mode_flag", want.mode_flag, got.mode_flag);
      cmp_field("checksum_value", want.checksum_value, got.checksum_value);
      cmp_field("stamp_us", want.stamp_us, got.stamp_us);
    endfunction
  endclass

endpackage

// ===== bench/tb_nmea_vtg_sentence_field_parser_core.sv =====
// ---------------------------------------------------------------------------
// tb_nmea_vtg_sentence_field_parser_core
// Streams VTG sentence bodies into the parser, one character per transaction,
// and checks every emitted record against the scoreboard's prediction.
// A few directed lines hit saturation, truncation, odd flags and checksum
// handling; then mostly well-formed random sentences plus noise lines, with
// random gaps on both sides and one long output hold-off.
// ---------------------------------------------------------------------------
module tb_nmea_vtg_sentence_field_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  import vtg_pkg::*;
  import vtg_record_sb_pkg::*;

  localparam int RANDOM_CHARS = 750;
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 400;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;

  vtg_record_sb      sb;
  int                chars_sent;
  bit                hold_done;
  bit                sender_burst;
  logic [CHAR_W-1:0] line_q[$];

  nmea_vtg_sentence_field_parser_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("** nmea_vtg_sentence_field_parser_core: FAILED **");
    $finish;
  end

  function int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_burst || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task send_char(logic [CHAR_W-1:0] c, logic [STAMP_W-1:0] now);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {now, c};
    do @(posedge clk); while (!in_tready);
    sb.note_char(c, now);
    chars_sent++;
  endtask

  task send_text(string s, logic [STAMP_W-1:0] now);
    for (int i = 0; i < s.len(); i++) send_char(s[i], now);
  endtask

  task send_line();
    sender_burst = ($urandom_range(0, 3) == 0);
    foreach (line_q[i]) send_char(line_q[i], $urandom());
    line_q.delete();
  endtask

  function logic [CHAR_W-1:0] blank_char();
    logic [CHAR_W-1:0] blanks[5];
    blanks = '{CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_FF};
    return blanks[$urandom_range(0, 4)];
  endfunction

  // sometimes follow a character with skipped whitespace
  function void put(logic [CHAR_W-1:0] c);
    line_q.push_back(c);
    if ($urandom_range(0, 99) < 6) line_q.push_back(blank_char());
  endfunction

  // any byte that does not close a field or the line
  function logic [CHAR_W-1:0] plain_byte();
    logic [CHAR_W-1:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_COMMA || c == CH_STAR || c == CH_NEWLINE);
    return c;
  endfunction

  function void add_number();
    int int_digits;
    if ($urandom_range(0, 9) == 0) int_digits = $urandom_range(4, 10);
    else int_digits = $urandom_range(0, 3);
    if ($urandom_range(0, 19) == 0) put(plain_byte());
    repeat (int_digits) put(8'(CH_ZERO + $urandom_range(0, 9)));
    if ($urandom_range(0, 99) < 70) begin
      put(CH_POINT);
      repeat ($urandom_range(0, 5)) put(8'(CH_ZERO + $urandom_range(0, 9)));
    end
    if ($urandom_range(0, 19) == 0) put(plain_byte());
  endfunction

  function void add_flag();
    string letters;
    int    r;
    letters = "TMNKADE";
    r = $urandom_range(0, 99);
    if (r < 70) put(letters[$urandom_range(0, letters.len() - 1)]);
    else if (r < 80) return;
    else put(plain_byte());
    if ($urandom_range(0, 9) == 0) put(plain_byte());
  endfunction

  function void build_sentence();
    string hex_chars;
    int    n_fields;
    hex_chars = "0123456789abcdefABCDEF";
    n_fields = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 8;
    for (int f = 0; f < n_fields; f++) begin
      if (f % 2 == 0) add_number();
      else add_flag();
      put(CH_COMMA);
    end
    if (n_fields == 8) add_flag();
    if ($urandom_range(0, 99) < 80) begin
      put(CH_STAR);
      repeat ($urandom_range(0, 3)) put(hex_chars[$urandom_range(0, hex_chars.len() - 1)]);
      if ($urandom_range(0, 9) == 0) put(CH_COMMA);
    end
    if ($urandom_range(0, 1)) line_q.push_back(CH_CR);
    line_q.push_back(CH_NEWLINE);
  endfunction

  function void build_noise();
    logic [CHAR_W-1:0] picks[6];
    picks = '{CH_COMMA, CH_STAR, CH_POINT, CH_ZERO, CH_NINE, CH_UC_F};
    repeat ($urandom_range(1, 30)) begin
      if ($urandom_range(0, 99) < 30) line_q.push_back(picks[$urandom_range(0, 5)]);
      else line_q.push_back(8'($urandom_range(0, 255)));
    end
    line_q.push_back(CH_NEWLINE);
  endfunction

  // output side: random ready pattern plus one long hold-off
  initial begin
    int n;
    out_tready <= 1'b0;
    hold_done = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!hold_done && chars_sent >= HOLD_AFTER) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1;
      end else begin
        n = $urandom_range(0, 99);
        if (n < 60) begin
          out_tready <= 1'b1;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end else begin
          out_tready <= 1'b0;
          if (n < 95) repeat ($urandom_range(1, 3)) @(posedge clk);
          else repeat ($urandom_range(10, 40)) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_record(out_tdata);
  end

  initial begin
    sb = new();
    chars_sent = 0;
    sender_burst = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // empty line right after reset: all-zero record
    send_char(CH_NEWLINE, 32'h0);
    // saturating course, truncated fraction, number stopped by junk,
    // NUL flag, sign-led speed, comma inside the checksum
    send_text("99999.9999,T,1x 5,", 32'hFFFF_FFFF);
    send_char(8'h00, 32'hFFFF_FFFF);
    send_char(8'hFF, 32'h0);
    send_text(",\t-7*aF,3\n", 32'h0);

    while (chars_sent < RANDOM_CHARS) begin
      if ($urandom_range(0, 9) == 0) build_noise();
      else build_sentence();
      send_line();
    end
    in_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** nmea_vtg_sentence_field_parser_core: PASSED **");
    end else begin
      $display("** nmea_vtg_sentence_field_parser_core: FAILED **");
    end
    $finish;
  end

endmodule
